### rtl/dtdc_pkg.sv
// Shared constants, types, lookup tables and the month decode function for the date to day code block.
package dtdc_pkg;

	// Width of the range code; the end date is start + 2^CODE_WIDTH - 2 (13 to 15).
	localparam int CODE_WIDTH = 14;

	localparam int DAY_W   = 7;
	localparam int MONTH_W = 24;
	localparam int YEAR_W  = 14;
	localparam int CODE_W  = 16;
	localparam int MNUM_W  = 4;
	localparam int MOFF_W  = 9;
	localparam int Q100_W  = 8;
	localparam int RD_W    = 24;

	// Rata Die landmarks
	localparam logic [RD_W-2:0] RD_JAN1_1990 = 23'd726468;
	localparam logic [RD_W-2:0] RD_START     = 23'd732312;
	localparam logic [RD_W-2:0] RD_JAN1_9999 = 23'd3651695;
	localparam logic [RD_W-2:0] RD_END       = 23'(732312 + (2 ** CODE_WIDTH) - 2);
	localparam logic [RD_W-1:0] RD_BIAS      = 24'd306;

	localparam logic [CODE_W-1:0] CODE_DOWN = 16'd1;
	localparam logic [CODE_W-1:0] CODE_UP   = 16'hFFFF;
	localparam logic [CODE_W-1:0] CODE_BASE = 16'd2;

	// y/100 as (y * 5243) >> 19, exact for every 14-bit year
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam int          PROD_W       = YEAR_W + 13;

	localparam logic [MNUM_W-1:0] MONTH_MAR = 4'd3;

	localparam logic [MONTH_W-1:0] MONTH_NAMES [12] = '{
		24'h4A414E, 24'h464542, 24'h4D4152, 24'h415052, 24'h4D4159, 24'h4A554E,
		24'h4A554C, 24'h415547, 24'h534550, 24'h4F4354, 24'h4E4F56, 24'h444543
	};

	// (153*m - 457)/5 with January and February (and the unknown code) taken
	// as months 13, 14 and 12 of the previous year
	localparam logic [MOFF_W-1:0] MONTH_OFFSET [13] = '{
		9'd275, 9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
		9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
	};

	typedef struct packed {
		logic                 valid;
		logic                 neg;
		logic [YEAR_W-1:0]    year;
		logic [Q100_W-1:0]    q100;
		logic [MOFF_W-1:0]    moff;
		logic [DAY_W-1:0]     day;
	} dtdc_stage_t;

	function automatic logic [MNUM_W-1:0] month_decode(input logic [MONTH_W-1:0] code);
		logic [MNUM_W-1:0] m;
		m = '0;
		for (int i = 0; i < 12; i++) begin
			if (code == MONTH_NAMES[i]) begin
				m = MNUM_W'(i + 1);
			end
		end
		return m;
	endfunction

endpackage

### rtl/dtdc_prep.sv
// Month decode, month offset lookup, year shift and year/100 reciprocal multiply, registered as stage two.
module dtdc_prep (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s1,
	input  logic [dtdc_pkg::DAY_W-1:0]      day_s1,
	input  logic [dtdc_pkg::MONTH_W-1:0]    month_s1,
	input  logic [dtdc_pkg::YEAR_W-1:0]     year_s1,
	output dtdc_pkg::dtdc_stage_t           stage_s2
);
	import dtdc_pkg::*;

	logic [MNUM_W-1:0] month_num;
	logic              wrap;
	logic [YEAR_W-1:0] year_adj;
	logic [PROD_W-1:0] prod;

	assign month_num = month_decode(month_s1);
	assign wrap      = month_num < MONTH_MAR;
	assign year_adj  = year_s1 - YEAR_W'(wrap);
	assign prod      = PROD_W'(year_adj) * PROD_W'(DIV100_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else begin
			stage_s2.valid <= valid_s1;
			stage_s2.neg   <= wrap && (year_s1 == '0);
			stage_s2.year  <= year_adj;
			stage_s2.q100  <= prod[DIV100_SHIFT +: Q100_W];
			stage_s2.moff  <= MONTH_OFFSET[month_num];
			stage_s2.day   <= day_s1;
		end
	end

endmodule

### rtl/dtdc_range.sv
// Rata Die sum and range encoding into the registered result.
module dtdc_range (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtdc_pkg::dtdc_stage_t           stage_s2,
	output logic                            valid_s3,
	output logic [dtdc_pkg::CODE_W-1:0]     code_s3,
	output logic                            below_s3,
	output logic                            above_s3
);
	import dtdc_pkg::*;

	logic [RD_W-2:0]   y365;
	logic [RD_W-1:0]   rd;
	logic [RD_W-2:0]   rd_mag;
	logic              neg;
	logic [CODE_W-1:0] code_c;
	logic              below_c;
	logic              above_c;

	assign y365 = (RD_W-1)'(stage_s2.year) * (RD_W-1)'(365);
	assign rd   = RD_W'(y365) + RD_W'(stage_s2.year >> 2) + RD_W'(stage_s2.q100 >> 2)
		+ RD_W'(stage_s2.moff) + RD_W'(stage_s2.day) - RD_W'(stage_s2.q100) - RD_BIAS;
	assign rd_mag = rd[RD_W-2:0];
	assign neg    = stage_s2.neg || rd[RD_W-1];

	always_comb begin
		code_c  = CODE_DOWN;
		below_c = 1'b0;
		above_c = 1'b0;
		if (!neg && rd_mag == RD_JAN1_1990) begin
			code_c = CODE_DOWN;
		end else if (neg || rd_mag < RD_START) begin
			below_c = 1'b1;
		end else if (rd_mag == RD_JAN1_9999) begin
			code_c = CODE_UP;
		end else if (rd_mag > RD_END) begin
			code_c  = CODE_UP;
			above_c = 1'b1;
		end else begin
			code_c = CODE_W'(rd_mag - RD_START) + CODE_BASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= stage_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		code_s3  <= code_c;
		below_s3 <= below_c;
		above_s3 <= above_c;
	end

endmodule

### rtl/date_to_day_code.sv
// Top level of the date to day code converter.
//
// Converts a calendar date (day, three-letter ASCII month, year) into a
// compact range code built on the Rata Die day number.
// Request channel: drive day_of_month, month_abbr and year_number and raise
// start; the request is taken at the clock edge where start is high and busy
// is low. busy never rises, so a request can be taken every cycle.
// Result channel: day_code, below_range and above_range are valid for one
// cycle while done is high. The receiver cannot stall the block.
// Pipeline, from the accepting edge to done: input register, month decode plus
// year/100 reciprocal multiply, Rata Die sum plus range compare.
// Throughput: one request per cycle.
// Codes: 1 for 1 Jan 1990 or any other date before 1 Jan 2006 (the others
// also raise below_range), 2 for 1 Jan 2006, 65535 for 1 Jan 9999 or
// anything past the end of the code range (the latter also raises above_range).
// Reset: arst_n clears the stage valid bits; no result is in flight after
// reset and done stays low until a new request has passed through.
module date_to_day_code (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [dtdc_pkg::DAY_W-1:0]      day_of_month,
	input  logic [dtdc_pkg::MONTH_W-1:0]    month_abbr,
	input  logic [dtdc_pkg::YEAR_W-1:0]     year_number,
	output logic                            done,
	output logic [dtdc_pkg::CODE_W-1:0]     day_code,
	output logic                            below_range,
	output logic                            above_range
);
	import dtdc_pkg::*;

	logic               accept;
	logic               valid_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [YEAR_W-1:0]  year_s1;
	dtdc_stage_t        stage_s2;

	// Every stage advances each cycle; never hold off a request.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Capture the request fields; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			day_s1   <= day_of_month;
			month_s1 <= month_abbr;
			year_s1  <= year_number;
		end
	end

	dtdc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.day_s1   (day_s1),
		.month_s1 (month_s1),
		.year_s1  (year_s1),
		.stage_s2 (stage_s2)
	);

	dtdc_range u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s2 (stage_s2),
		.valid_s3 (done),
		.code_s3  (day_code),
		.below_s3 (below_range),
		.above_s3 (above_range)
	);

	// An accepted request produces a result at done once it has passed the input, prep and range registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("result missing three cycles after request");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(arst_n, 3)) |-> $past(accept, 3))
		else $error("result without a matching request");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(below_range && above_range))
		else $error("both range flags set");

	a_below_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && below_range) |-> (day_code == CODE_DOWN))
		else $error("below range without infinity-down code");

	a_above_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && above_range) |-> (day_code == CODE_UP))
		else $error("above range without infinity-up code");

endmodule
